[design/ffha_pkg.sv]
`default_nettype none
package ffha_pkg;
    localparam int GRANULE_BYTES = 8;
    localparam int HEADER_BYTES  = 16;
    localparam int HDR_GRANULES  = HEADER_BYTES / GRANULE_BYTES;
    localparam int MIN_REST_GRAN = (HEADER_BYTES + 16) / GRANULE_BYTES;

    localparam int OP_W     = 2;
    localparam int REQ_W    = 19;
    localparam int OFF_W    = 18;
    localparam int ST_W     = 2;
    localparam int CNT_W    = 19;
    localparam int NEED_W   = REQ_W - 2;

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;

    localparam t_op OP_ALLOC   = 2'd0;
    localparam t_op OP_RELEASE = 2'd1;

    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_NOSPACE = 2'd1;
    localparam t_status ST_INVALID = 2'd2;
endpackage
`default_nettype wire

[design/first_fit_heap_allocator.sv]
`default_nettype none
// First-fit heap allocator. Block headers sit in one single-port-write,
// registered-read memory with one entry per 8-byte granule. After reset the
// block runs a clearing pass over all HEAP_BYTES/8 entries (32768 by default)
// before it takes its first request. Any other operation is a status query
// that only reports the byte counts. An allocate walks the headers from the
// heap start, with one more step when the block is split. A release checks the
// freed header, absorbs a free next block, rewrites the header, then walks from
// the heap start to the freed block, with one more step when it merges with
// the previous block; the single memory read port sets the walk speed.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES = 262144
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire  [ffha_pkg::OP_W-1:0]  i_operation,
    input  wire  [ffha_pkg::REQ_W-1:0] i_request_bytes,
    input  wire  [ffha_pkg::OFF_W-1:0] i_payload_offset,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic [ffha_pkg::ST_W-1:0]  o_status,
    output logic [ffha_pkg::OFF_W-1:0] o_granted_offset,
    output logic [ffha_pkg::CNT_W-1:0] o_used_bytes,
    output logic [ffha_pkg::CNT_W-1:0] o_free_bytes
);
    localparam int GRANULES = HEAP_BYTES / ffha_pkg::GRANULE_BYTES;
    localparam int AW = $clog2(GRANULES);
    localparam int UW = AW + 1;
    localparam int DW = AW + 2;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_AWALK = 4'd2;
    localparam logic [3:0] S_ASPL  = 4'd3;
    localparam logic [3:0] S_RB    = 4'd4;
    localparam logic [3:0] S_RN    = 4'd5;
    localparam logic [3:0] S_RWB   = 4'd6;
    localparam logic [3:0] S_RWALK = 4'd7;
    localparam logic [3:0] S_RWP2  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [DW-1:0] mem [GRANULES];
    logic [DW-1:0] r_rd;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_b, n_b;
    logic [AW-1:0] r_p, n_p;
    logic [AW-1:0] r_sz, n_sz;
    logic [ffha_pkg::NEED_W-1:0] r_need, n_need;
    logic [UW-1:0] r_used, n_used;
    ffha_pkg::t_status r_st, n_st;
    logic [ffha_pkg::OFF_W-1:0] r_grant, n_grant;
    logic          r_ovld, n_ovld;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] wr_data;

    logic [AW-1:0] rd_size;
    logic          rd_free, rd_valid;
    logic [UW-1:0] rd_next;
    logic [ffha_pkg::OFF_W-1:0] rel_bg;

    assign rd_size  = r_rd[AW-1:0];
    assign rd_valid = r_rd[AW];
    assign rd_free  = r_rd[AW+1];
    assign rd_next  = UW'(r_b) + UW'(ffha_pkg::HDR_GRANULES) + UW'(rd_size);
    assign rel_bg   = (i_payload_offset >> 3) - ffha_pkg::OFF_W'(ffha_pkg::HDR_GRANULES);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        logic [UW-1:0] pnext;
        pnext   = UW'(r_p) + UW'(ffha_pkg::HDR_GRANULES) + UW'(rd_size);
        n_state = r_state;
        n_b     = r_b;
        n_p     = r_p;
        n_sz    = r_sz;
        n_need  = r_need;
        n_used  = r_used;
        n_st    = r_st;
        n_grant = r_grant;
        n_ovld  = r_ovld & i_out_stall;
        wr_en   = 1'b0;
        wr_addr = r_b;
        wr_data = '0;
        rd_addr = r_b;
        unique case (r_state)
            S_CLR: begin
                wr_en = 1'b1;
                if (r_b == '0) begin
                    wr_data = {1'b1, 1'b1,
                               AW'(GRANULES - ffha_pkg::HDR_GRANULES)};
                end
                n_b = r_b + 1'b1;
                if (32'(r_b) == 32'(GRANULES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_st    = ffha_pkg::ST_DONE;
                    n_grant = '0;
                    n_state = S_DONE;
                    if (i_operation == ffha_pkg::OP_ALLOC) begin
                        n_need = ffha_pkg::NEED_W'((20'(i_request_bytes) + 20'd7) >> 3);
                        if (i_request_bytes == '0) begin
                            n_st = ffha_pkg::ST_NOSPACE;
                        end else begin
                            n_b     = '0;
                            rd_addr = '0;
                            n_state = S_AWALK;
                        end
                    end else if (i_operation == ffha_pkg::OP_RELEASE) begin
                        if (i_payload_offset < ffha_pkg::OFF_W'(ffha_pkg::HEADER_BYTES) ||
                            i_payload_offset[2:0] != 3'd0 ||
                            32'(rel_bg) >= 32'(GRANULES)) begin
                            n_st = ffha_pkg::ST_INVALID;
                        end else begin
                            n_b     = AW'(rel_bg);
                            rd_addr = AW'(rel_bg);
                            n_state = S_RB;
                        end
                    end
                end
            end
            S_AWALK: begin
                if (rd_free && 32'(rd_size) >= 32'(r_need)) begin
                    if (32'(rd_size) >= 32'(r_need) + 32'(ffha_pkg::MIN_REST_GRAN)) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(32'(r_b) + 32'(ffha_pkg::HDR_GRANULES) + 32'(r_need));
                        wr_data = {1'b1, 1'b1, AW'(32'(rd_size) - 32'(r_need)
                                   - 32'(ffha_pkg::HDR_GRANULES))};
                        n_sz    = AW'(r_need);
                        n_state = S_ASPL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = {1'b0, 1'b1, rd_size};
                        n_used  = r_used + UW'(rd_size) + UW'(ffha_pkg::HDR_GRANULES);
                        n_grant = ffha_pkg::OFF_W'((32'(r_b) + 32'(ffha_pkg::HDR_GRANULES)) << 3);
                        n_state = S_DONE;
                    end
                end else if (32'(rd_next) >= 32'(GRANULES)) begin
                    n_st    = ffha_pkg::ST_NOSPACE;
                    n_state = S_DONE;
                end else begin
                    n_b     = AW'(rd_next);
                    rd_addr = AW'(rd_next);
                end
            end
            S_ASPL: begin
                wr_en   = 1'b1;
                wr_data = {1'b0, 1'b1, r_sz};
                n_used  = r_used + UW'(r_sz) + UW'(ffha_pkg::HDR_GRANULES);
                n_grant = ffha_pkg::OFF_W'((32'(r_b) + 32'(ffha_pkg::HDR_GRANULES)) << 3);
                n_state = S_DONE;
            end
            S_RB: begin
                if (!rd_valid || rd_free) begin
                    n_st    = ffha_pkg::ST_INVALID;
                    n_state = S_DONE;
                end else begin
                    n_sz   = rd_size;
                    n_used = r_used - UW'(rd_size) - UW'(ffha_pkg::HDR_GRANULES);
                    if (32'(rd_next) < 32'(GRANULES)) begin
                        rd_addr = AW'(rd_next);
                        n_p     = AW'(rd_next);
                        n_state = S_RN;
                    end else begin
                        n_state = S_RWB;
                    end
                end
            end
            S_RN: begin
                // absorb a free next block
                if (rd_valid && rd_free) begin
                    wr_en   = 1'b1;
                    wr_addr = r_p;
                    wr_data = '0;
                    n_sz    = AW'(32'(r_sz) + 32'(ffha_pkg::HDR_GRANULES) + 32'(rd_size));
                end
                n_state = S_RWB;
            end
            S_RWB: begin
                wr_en   = 1'b1;
                wr_data = {1'b1, 1'b1, r_sz};
                rd_addr = '0;
                n_p     = '0;
                n_state = (r_b == '0) ? S_DONE : S_RWALK;
            end
            S_RWALK: begin
                if (32'(pnext) < 32'(r_b)) begin
                    n_p     = AW'(pnext);
                    rd_addr = AW'(pnext);
                end else if (rd_free && 32'(pnext) == 32'(r_b)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_p;
                    wr_data = {1'b1, 1'b1, AW'(32'(rd_size)
                               + 32'(ffha_pkg::HDR_GRANULES) + 32'(r_sz))};
                    n_state = S_RWP2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RWP2: begin
                wr_en   = 1'b1;
                wr_data = '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (!r_ovld || !i_out_stall) begin
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_b     <= '0;
            r_used  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_b     <= n_b;
            r_used  <= n_used;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_sz    <= n_sz;
        r_need  <= n_need;
        r_st    <= n_st;
        r_grant <= n_grant;
        if (r_state == S_DONE && (!r_ovld || !i_out_stall)) begin
            o_status         <= r_st;
            o_granted_offset <= r_grant;
            o_used_bytes     <= ffha_pkg::CNT_W'(32'(r_used) << 3);
            o_free_bytes     <= ffha_pkg::CNT_W'(32'(HEAP_BYTES) - (32'(r_used) << 3));
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
endmodule
`default_nettype wire
